### rtl/core/assert_macros.svh
// Assertion helper macros for the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/bse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_pkg
// Shared types, constants and functions of the bitmap store engine.
// ----------------------------------------------------------------------------
package bse_pkg;

   localparam int STORE_WORDS = 64;
   localparam int WORD_BITS   = 64;
   localparam int WIDX_W      = $clog2(STORE_WORDS);
   localparam int BIDX_W      = 12;
   localparam int CNT_W       = 13;
   localparam int AW_W        = 7;
   localparam int WCNT_W      = $clog2(STORE_WORDS + 1);
   localparam int PCNT_W      = 7;

   localparam int REQ_DATA_W  = 88;
   localparam int RSP_DATA_W  = 96;

   typedef enum logic [3:0] {
      ACT_SET     = 4'd0,
      ACT_CLEAR   = 4'd1,
      ACT_TEST    = 4'd2,
      ACT_CLR_ALL = 4'd3,
      ACT_COUNT   = 4'd4,
      ACT_FIRST   = 4'd5,
      ACT_NEXT    = 4'd6,
      ACT_OR      = 4'd7,
      ACT_AND     = 4'd8,
      ACT_XOR     = 4'd9,
      ACT_COMMON  = 4'd10,
      ACT_INVERT  = 4'd11,
      ACT_READ    = 4'd12,
      ACT_WRITE   = 4'd13,
      ACT_BAD14   = 4'd14,
      ACT_BAD15   = 4'd15
   } action_type;

   // Datapath commands issued by the controller
   typedef struct packed {
      logic                load;     // capture request and clear accumulators
      logic                rd;       // read word at rd_addr
      logic [WIDX_W-1:0]   rd_addr;
      logic                modify;   // compute RMW result from read data
      logic                wr;       // write back modified word
      logic                acc;      // accumulate count / search on read data
      logic                first;    // first word of a walk (apply start mask)
      logic                inv;      // walk writes inverted words
      logic                clr_step; // clear word at rd_addr
      logic                err;      // report status error
      logic                done;     // present the result
   } cmd_type;

   typedef struct packed {
      logic found;               // search hit seen
   } sts_type;

   typedef struct packed {
      logic                bit_value;
      logic [CNT_W-1:0]    count;
      logic                found;
      logic [BIDX_W-1:0]   position;
      logic                changed;
      logic [WORD_BITS-1:0] word_out;
      logic                status;
   } rsp_type;

   // Pairwise tree sum of the bits, byte sums folded in three steps
   function automatic logic [PCNT_W-1:0] popcount64(input logic [WORD_BITS-1:0] v);
      logic [WORD_BITS-1:0] s1, s2, s4, s8, s16, s32;
      s1  = v - ((v >> 1) & 64'h5555_5555_5555_5555);
      s2  = (s1 & 64'h3333_3333_3333_3333) + ((s1 >> 2) & 64'h3333_3333_3333_3333);
      s4  = (s2 + (s2 >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
      s8  = s4 + (s4 >> 8);
      s16 = s8 + (s8 >> 16);
      s32 = s16 + (s16 >> 32);
      return s32[PCNT_W-1:0];
   endfunction

   // Lowest set bit of a word; valid only when the word is nonzero
   function automatic logic [5:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) if (v[i]) p = 6'(i);
      return p;
   endfunction

endpackage

### rtl/core/bse_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_datapath
// Word memory, read-modify-write unit, count and search accumulators.
// ----------------------------------------------------------------------------
module bse_datapath (
   input  logic                    clock,
   input  bse_pkg::cmd_type        cmd,
   input  bse_pkg::action_type     action,
   input  logic [11:0]             bit_index,
   input  logic [63:0]             word_data,
   output bse_pkg::sts_type        sts,
   output bse_pkg::rsp_type        rsp
);
   import bse_pkg::*;

   logic [WORD_BITS-1:0] mem [STORE_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic [WIDX_W-1:0]    addr_ff;

   action_type           act_ff;
   logic [BIDX_W-1:0]    bidx_ff;
   logic [WORD_BITS-1:0] data_ff;
   logic [WORD_BITS-1:0] nw_ff, nw_in;
   logic                 chg_ff;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 fnd_ff, fnd_in;
   logic [BIDX_W-1:0]    pos_ff, pos_in;
   logic [WORD_BITS-1:0] mask, smask, sword;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= mem[cmd.rd_addr];
         addr_ff  <= cmd.rd_addr;
      end
      if (cmd.clr_step) mem[cmd.rd_addr] <= '0;
      else if (cmd.wr)  mem[addr_ff] <= nw_in;
      else if (cmd.inv) mem[addr_ff] <= ~rdata_ff;
   end

   assign mask  = WORD_BITS'(1) << bidx_ff[5:0];
   assign smask = cmd.first ? ({WORD_BITS{1'b1}} << bidx_ff[5:0]) : {WORD_BITS{1'b1}};
   assign sword = rdata_ff & smask;

   always_comb begin
      unique case (act_ff)
         ACT_SET:   nw_in = rdata_ff | mask;
         ACT_CLEAR: nw_in = rdata_ff & ~mask;
         ACT_OR:    nw_in = rdata_ff | data_ff;
         ACT_AND:   nw_in = rdata_ff & data_ff;
         ACT_XOR:   nw_in = rdata_ff ^ data_ff;
         ACT_WRITE: nw_in = data_ff;
         default:   nw_in = rdata_ff;
      endcase
      cnt_in = cnt_ff;
      fnd_in = fnd_ff;
      pos_in = pos_ff;
      if (act_ff == ACT_COUNT) cnt_in = cnt_ff + CNT_W'(popcount64(rdata_ff));
      else if ((act_ff == ACT_FIRST || act_ff == ACT_NEXT) && !fnd_ff && sword != '0) begin
         fnd_in = 1'b1;
         pos_in = {addr_ff, lowest_set(sword)};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= action;
         bidx_ff <= bit_index;
         data_ff <= word_data;
         cnt_ff  <= '0;
         fnd_ff  <= 1'b0;
         pos_ff  <= '0;
      end else if (cmd.acc) begin
         cnt_ff <= cnt_in;
         fnd_ff <= fnd_in;
         pos_ff <= pos_in;
      end
      if (cmd.modify) begin
         nw_ff  <= nw_in;
         chg_ff <= nw_in != rdata_ff;
         if (act_ff == ACT_COMMON) cnt_ff <= CNT_W'(popcount64(rdata_ff & data_ff));
      end
   end

   assign sts.found = fnd_ff;

   always_comb begin
      rsp = '0;
      if (cmd.err) rsp.status = 1'b1;
      else begin
         unique case (act_ff)
            ACT_SET, ACT_CLEAR, ACT_TEST: begin
               rsp.word_out  = nw_ff;
               rsp.changed   = chg_ff;
               rsp.bit_value = |(nw_ff & mask);
            end
            ACT_OR, ACT_AND, ACT_XOR, ACT_WRITE: begin
               rsp.word_out = nw_ff;
               rsp.changed  = chg_ff;
            end
            ACT_READ:   rsp.word_out = nw_ff;
            ACT_COMMON: begin
               rsp.word_out = nw_ff;
               rsp.count    = cnt_ff;
            end
            ACT_COUNT:  rsp.count = cnt_ff;
            ACT_FIRST, ACT_NEXT: begin
               rsp.found    = fnd_ff;
               rsp.position = pos_ff;
            end
            default: rsp = '0;
         endcase
      end
   end
endmodule

### rtl/core/bse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer: accepts a request, walks the memory, hands off a result.
// ----------------------------------------------------------------------------
module bse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  bse_pkg::action_type  action,
   input  logic [11:0]          bit_index,
   input  logic [5:0]           word_sel,
   input  logic [6:0]           active_words,
   input  bse_pkg::sts_type     sts,
   input  logic                 out_free,
   output logic                 busy,
   output bse_pkg::cmd_type     cmd
);
   import bse_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_RD    = 6'b000010,
      S_MOD   = 6'b000100,
      S_WALK  = 6'b001000,
      S_CLR   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   action_type         act_ff;
   logic [WIDX_W-1:0]  ptr_ff, ptr_in;
   logic [WIDX_W-1:0]  last_ff;
   logic               err_ff, err_in;
   logic               first_ff, first_in;
   logic               walk_v_ff, walk_v_in;
   logic [WCNT_W-1:0]  nw;
   logic               bad;

   // Effective size saturated into 1..STORE_WORDS
   always_comb begin
      if (active_words == '0) nw = WCNT_W'(1);
      else if (32'(active_words) > STORE_WORDS) nw = WCNT_W'(STORE_WORDS);
      else nw = WCNT_W'(active_words);
   end

   always_comb begin
      unique case (action)
         ACT_SET, ACT_CLEAR, ACT_TEST, ACT_NEXT: bad = 32'(bit_index[11:6]) >= 32'(nw);
         ACT_OR, ACT_AND, ACT_XOR, ACT_COMMON, ACT_READ, ACT_WRITE:
            bad = 32'(word_sel) >= 32'(nw);
         ACT_BAD14, ACT_BAD15: bad = 1'b1;
         default: bad = 1'b0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      ptr_in    = ptr_ff;
      err_in    = err_ff;
      first_in  = first_ff;
      walk_v_in = 1'b0;
      cmd       = '0;
      cmd.rd_addr = ptr_ff;
      busy      = state_ff != S_IDLE;
      // accumulate on data read in previous cycle
      cmd.acc   = walk_v_ff;
      cmd.first = walk_v_ff && first_ff;
      cmd.inv   = walk_v_ff && act_ff == ACT_INVERT;
      if (walk_v_ff) first_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load = 1'b1;
               err_in   = bad;
               first_in = action == ACT_NEXT;
               if (bad) state_in = S_DONE;
               else begin
                  unique case (action)
                     ACT_CLR_ALL: begin
                        ptr_in = '0;
                        state_in = S_CLR;
                     end
                     ACT_COUNT, ACT_FIRST, ACT_NEXT, ACT_INVERT: begin
                        ptr_in = (action == ACT_NEXT) ? bit_index[11:6] : '0;
                        state_in = S_WALK;
                     end
                     ACT_SET, ACT_CLEAR, ACT_TEST: begin
                        ptr_in = bit_index[11:6];
                        state_in = S_RD;
                     end
                     default: begin
                        ptr_in = word_sel;
                        state_in = S_RD;
                     end
                  endcase
               end
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_MOD;
         end
         S_MOD: begin
            cmd.modify = 1'b1;
            cmd.wr     = 1'b1;
            state_in   = S_DONE;
         end
         S_WALK: begin
            // stop issuing reads once a hit is in hand
            if (!(sts.found || (act_ff != ACT_COUNT && act_ff != ACT_INVERT
                                 && walk_v_ff && cmd.acc && 1'b0))) begin
               cmd.rd    = 1'b1;
               walk_v_in = 1'b1;
            end
            if (ptr_ff == last_ff || sts.found) state_in = S_MOD;
            else ptr_in = ptr_ff + 1'b1;
         end
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (ptr_ff == WIDX_W'(STORE_WORDS - 1)) state_in = S_DONE;
            else ptr_in = ptr_ff + 1'b1;
         end
         S_DONE: begin
            cmd.err  = err_ff;
            cmd.done = out_free;
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // Walk tail: S_MOD after a walk only drains the last read
      if (state_ff == S_MOD && act_ff != ACT_SET && act_ff != ACT_CLEAR
          && act_ff != ACT_TEST && act_ff != ACT_OR && act_ff != ACT_AND
          && act_ff != ACT_XOR && act_ff != ACT_COMMON && act_ff != ACT_READ
          && act_ff != ACT_WRITE) begin
         cmd.modify = 1'b0;
         cmd.wr     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         walk_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         walk_v_ff <= walk_v_in;
      end
      ptr_ff   <= ptr_in;
      err_ff   <= err_in;
      first_ff <= first_in;
      if (req_fire && state_ff == S_IDLE) begin
         act_ff  <= action;
         last_ff <= WIDX_W'(nw - 1'b1);
      end
   end
endmodule

### rtl/core/bitmap_store_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_store_engine_core
// Bitmap of 64 words of 64 bits with bit, word, count and search actions.
// ----------------------------------------------------------------------------
// From accept to rsp_tvalid: bit and word actions read, modify and write back,
// then fill the result register; a range error or unknown action goes straight
// to the result register; count and invert walk the active words; a search
// stops reading at its first hit; clear all sweeps 64 words.
// One request in flight; a full result register adds its stall. Synchronous reset
// clears the control state, then a sweep clears all 64 words, req_tready low.
module bitmap_store_engine_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [6:0]   csr_wdata,      // active_words
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [87:0]  req_tdata,      // action[3:0] bit_index[15:4] word_sel[21:16]
                                        // word_data[85:22], zero pad [87:86]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata       // bit_value[0] count[13:1] found[14]
                                        // position[26:15] changed[27] word_out[91:28]
                                        // status[92], zero pad [95:93]
);
   import bse_pkg::*;
   `include "assert_macros.svh"

   logic [6:0]  active_ff;
   logic        init_ff;
   logic        busy;
   logic        req_fire;
   logic        out_free;
   cmd_type     cmd, cmd_mux;
   sts_type     sts;
   rsp_type     rsp;
   logic [5:0]  init_ptr_ff;
   logic        rsp_v_ff;
   logic [95:0] rsp_d_ff;
   action_type  action;

   assign action = action_type'(req_tdata[3:0]);

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) active_ff <= 7'd64;
      else if (csr_we) active_ff <= csr_wdata;
   end

   // Clearing sweep after reset; hold off requests until done
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= 1'b1;
         init_ptr_ff <= '0;
      end else if (init_ff) begin
         init_ptr_ff <= init_ptr_ff + 1'b1;
         if (init_ptr_ff == 6'(STORE_WORDS - 1)) init_ff <= 1'b0;
      end
   end

   assign req_tready = !init_ff && !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_v_ff || rsp_tready;

   bse_ctrl u_ctrl (
      .clock, .reset, .req_fire, .action,
      .bit_index(req_tdata[15:4]), .word_sel(req_tdata[21:16]),
      .active_words(active_ff), .sts, .out_free, .busy, .cmd
   );

   always_comb begin
      cmd_mux = cmd;
      if (init_ff) begin
         cmd_mux          = '0;
         cmd_mux.clr_step = 1'b1;
         cmd_mux.rd_addr  = init_ptr_ff;
      end
   end

   bse_datapath u_dp (
      .clock, .cmd(cmd_mux), .action,
      .bit_index(req_tdata[15:4]),
      .word_data(req_tdata[85:22]), .sts, .rsp
   );

   // Output register parts the result from the sequencer
   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (cmd.done) rsp_v_ff <= 1'b1;
      else if (rsp_tready) rsp_v_ff <= 1'b0;
      if (cmd.done)
         rsp_d_ff <= {3'b0, rsp.status, rsp.word_out, rsp.changed, rsp.position,
                      rsp.found, rsp.count, rsp.bit_value};
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   `ASSERT_CLK(a_no_accept_in_init, clock, reset, init_ff |-> !req_tready, "accept during clear")
   `ASSERT_CLK(a_done_needs_room, clock, reset, cmd.done |-> out_free, "result overwrite")
   `ASSERT_CLK(a_busy_after_fire, clock, reset, req_fire |=> busy, "sequencer did not start")
endmodule
